// ----- rtl/core/magnetometer_heading_cordic_assert.svh -----
// Assertion macros for the magnetometer heading CORDIC block.
`ifndef MAGNETOMETER_HEADING_CORDIC_ASSERT_SVH
`define MAGNETOMETER_HEADING_CORDIC_ASSERT_SVH

// Implication checked on every rising edge of clk_i outside reset.
`define MHC_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant checked on every rising edge of clk_i outside reset.
`define MHC_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

// ----- rtl/core/mhc_pkg.sv -----
// Shared widths, constants, register codes and types of the heading CORDIC.
package mhc_pkg;

  localparam int IN_W   = 16;
  localparam int XY_W   = 27;
  localparam int Z_W    = 21;
  localparam int ROT_W  = 15;
  localparam int BEAR_W = 16;
  localparam int HEAD_W = 15;
  localparam int IDX_W  = 2;

  localparam logic signed [Z_W-1:0] PI_Q16 = 21'sd205887;

  localparam logic signed [IN_W-1:0]  X_OFFSET_RST   = -16'sd1711;
  localparam logic signed [IN_W-1:0]  Y_OFFSET_RST   = 16'sd2895;
  localparam logic        [ROT_W-1:0] ROT_OFFSET_RST = 15'd17157;

  typedef enum logic [IDX_W-1:0] {
    REG_X_OFFSET   = 2'd0,
    REG_Y_OFFSET   = 2'd1,
    REG_ROT_OFFSET = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  // Rounded atan(2^-i) in radians * 65536; zero from stage 17 on.
  function automatic logic signed [Z_W-1:0] atan_q16(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:       r = 21'sd51472;
      1:       r = 21'sd30386;
      2:       r = 21'sd16055;
      3:       r = 21'sd8150;
      4:       r = 21'sd4091;
      5:       r = 21'sd2047;
      6:       r = 21'sd1024;
      7:       r = 21'sd512;
      8:       r = 21'sd256;
      9:       r = 21'sd128;
      10:      r = 21'sd64;
      11:      r = 21'sd32;
      12:      r = 21'sd16;
      13:      r = 21'sd8;
      14:      r = 21'sd4;
      15:      r = 21'sd2;
      16:      r = 21'sd1;
      default: r = 21'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/mhc_pre.sv -----
// Input stage: hard-iron correction, scaling and left half-plane fold.
module mhc_pre (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [mhc_pkg::IN_W-1:0]      x_off_i,
  input  logic signed [mhc_pkg::IN_W-1:0]      y_off_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [mhc_pkg::IN_W-1:0]      x_raw_i,
  input  logic signed [mhc_pkg::IN_W-1:0]      y_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mhc_pkg::vec_t                        out_vec_o
);
  import mhc_pkg::*;

  logic signed [IN_W-1:0] xc, yc;
  logic signed [XY_W-1:0] xw, yw;
  vec_t                   vec_d, vec_q;
  logic                   valid_q;
  logic                   take;

  // Sums wrap to 16 bits before the scale by 256.
  assign xc = x_raw_i + x_off_i;
  assign yc = y_raw_i + y_off_i;
  assign xw = {{(XY_W-IN_W-8){xc[IN_W-1]}}, xc, 8'h00};
  assign yw = {{(XY_W-IN_W-8){yc[IN_W-1]}}, yc, 8'h00};

  always_comb begin
    vec_d.x = xw;
    vec_d.y = yw;
    vec_d.z = '0;
    if (xw < 0) begin
      vec_d.x = -xw;
      vec_d.y = -yw;
      vec_d.z = (yw >= 0) ? PI_Q16 : -PI_Q16;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

endmodule

// ----- rtl/core/mhc_cell.sv -----
// One CORDIC vectoring cell: a single micro-rotation and its pipeline register.
module mhc_cell #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mhc_pkg::vec_t in_vec_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mhc_pkg::vec_t out_vec_o
);
  import mhc_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_q16(STAGE_IDX);

  logic signed [XY_W-1:0] xi, yi, dx, dy;
  logic signed [Z_W-1:0]  zi;
  vec_t                   vec_d, vec_q;
  logic                   valid_q;
  logic                   take;

  assign xi = in_vec_i.x;
  assign yi = in_vec_i.y;
  assign zi = in_vec_i.z;
  assign dx = yi >>> STAGE_IDX;
  assign dy = xi >>> STAGE_IDX;

  // A residual of exactly zero leaves the vector and the angle untouched.
  always_comb begin
    vec_d = in_vec_i;
    if (yi > 0) begin
      vec_d.x = xi + dx;
      vec_d.y = yi - dy;
      vec_d.z = zi + ATAN;
    end else if (yi < 0) begin
      vec_d.x = xi - dx;
      vec_d.y = yi + dy;
      vec_d.z = zi - ATAN;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

endmodule

// ----- rtl/core/mhc_post.sv -----
// Output stages: rescale, rotation offset, saturation, degree conversion and wrap into one turn.
module mhc_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic        [mhc_pkg::ROT_W-1:0]     rot_off_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [mhc_pkg::Z_W-1:0]       z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mhc_pkg::BEAR_W-1:0]    bearing_o,
  output logic        [mhc_pkg::HEAD_W-1:0]    heading_o
);
  import mhc_pkg::*;

  localparam int ZR_W   = Z_W + 1;
  localparam int A_W    = ZR_W - 4;
  localparam int B_W    = A_W + 1;
  localparam int M_W    = 22;
  localparam int PROD_W = B_W + M_W;
  localparam int H_W    = PROD_W - 20;

  localparam logic signed [M_W-1:0]    DEG_MUL   = 22'sd938734;
  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(64'sd524288);
  localparam logic signed [H_W-1:0]    TURN1     = H_W'(23040);
  localparam logic signed [H_W-1:0]    TURN2     = H_W'(46080);
  localparam logic signed [H_W-1:0]    TURN3     = H_W'(69120);
  localparam logic signed [B_W-1:0]    BEAR_MAX  = B_W'(32767);
  localparam logic signed [B_W-1:0]    BEAR_MIN  = -B_W'(32768);

  logic signed [ZR_W-1:0]   zr;
  logic signed [A_W-1:0]    a12;
  logic signed [B_W-1:0]    b;
  logic signed [BEAR_W-1:0] bear_d;
  logic signed [PROD_W-1:0] rsum;
  logic signed [H_W-1:0]    hs, hw;

  logic                     v0_q, v1_q, v2_q;
  logic                     rdy0, rdy1, rdy2;
  logic signed [B_W-1:0]    b0_q;
  logic signed [BEAR_W-1:0] bear0_q, bear1_q, bear2_q;
  logic signed [PROD_W-1:0] prod1_q;
  logic        [HEAD_W-1:0] head2_q;

  // Stage 0: round the angle to radians * 4096 and take off the mounting rotation.
  assign zr  = {z_i[Z_W-1], z_i} + ZR_W'(8);
  assign a12 = A_W'(zr >>> 4);
  assign b   = {a12[A_W-1], a12} - {{(B_W-ROT_W){1'b0}}, rot_off_i};

  always_comb begin
    if (b > BEAR_MAX) begin
      bear_d = BEAR_MAX[BEAR_W-1:0];
    end else if (b < BEAR_MIN) begin
      bear_d = BEAR_MIN[BEAR_W-1:0];
    end else begin
      bear_d = b[BEAR_W-1:0];
    end
  end

  // Stage 2: round the scaled product and bring the heading into one turn.
  assign rsum = prod1_q + ROUND_ADD;
  assign hs   = rsum[PROD_W-1:20];

  always_comb begin
    if (hs < -TURN2) begin
      hw = hs + TURN3;
    end else if (hs < -TURN1) begin
      hw = hs + TURN2;
    end else if (hs < 0) begin
      hw = hs + TURN1;
    end else if (hs >= TURN1) begin
      hw = hs - TURN1;
    end else begin
      hw = hs;
    end
  end

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      b0_q    <= b;
      bear0_q <= bear_d;
    end
    if (rdy1 && v0_q) begin
      prod1_q <= b0_q * DEG_MUL;
      bear1_q <= bear0_q;
    end
    if (rdy2 && v1_q) begin
      head2_q <= hw[HEAD_W-1:0];
      bear2_q <= bear1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign bearing_o   = bear2_q;
  assign heading_o   = head2_q;

endmodule

// ----- rtl/core/magnetometer_heading_cordic.sv -----
// Top level of the magnetometer compass heading block built on a CORDIC cell chain.
//
// Each request on the slave stream carries one raw X/Y sample pair; each
// request on the master stream carries the bearing in radians * 4096 and the
// heading in 1/64 degree for that sample, in order, one result per sample.
// Hard-iron offsets and the mounting rotation are set through the write port
// (index 0: X offset, 1: Y offset, 2: rotation); write them only while idle.
// The pipeline is one input stage, one cell per CORDIC stage and three output
// stages (rescale, multiply, wrap and output register).
// Throughput is one sample per cycle with no stall; each stage holds its own valid bit.
// When the receiver stalls, the output register holds its result and stages
// behind it keep filling empty slots, so s_axis_tready drops only once the
// whole chain is full. Reset empties the pipeline and loads the default
// offsets; no sweep is needed after reset.
`include "magnetometer_heading_cordic_assert.svh"

module magnetometer_heading_cordic #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: x_raw [15:0], y_raw [31:16]
  input  logic [31:0]                        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: bearing_rad [15:0], heading_deg [30:16], zero [31]
  output logic [31:0]                        m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [mhc_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [mhc_pkg::IN_W-1:0]           cfg_wdata_i
);
  import mhc_pkg::*;

  logic signed [IN_W-1:0]   x_off_q, y_off_q;
  logic        [ROT_W-1:0]  rot_off_q;

  vec_t                     chain_vec   [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]   chain_valid;
  logic [CORDIC_STAGES:0]   chain_ready;

  logic signed [BEAR_W-1:0] bearing;
  logic        [HEAD_W-1:0] heading;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q   <= X_OFFSET_RST;
      y_off_q   <= Y_OFFSET_RST;
      rot_off_q <= ROT_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_X_OFFSET:   x_off_q   <= cfg_wdata_i;
        REG_Y_OFFSET:   y_off_q   <= cfg_wdata_i;
        REG_ROT_OFFSET: rot_off_q <= cfg_wdata_i[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  mhc_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .x_off_i     (x_off_q),
    .y_off_i     (y_off_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .x_raw_i     (s_axis_tdata[IN_W-1:0]),
    .y_raw_i     (s_axis_tdata[2*IN_W-1:IN_W]),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_vec_o   (chain_vec[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    mhc_cell #(
      .STAGE_IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_vec_i    (chain_vec[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_vec_o   (chain_vec[g+1])
    );
  end

  mhc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_off_i   (rot_off_q),
    .in_valid_i  (chain_valid[CORDIC_STAGES]),
    .in_ready_o  (chain_ready[CORDIC_STAGES]),
    .z_i         (chain_vec[CORDIC_STAGES].z),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .bearing_o   (bearing),
    .heading_o   (heading)
  );

  assign m_axis_tdata = {1'b0, heading, bearing};

  // A ready receiver means every stage can move, so the input is never blocked.
  `MHC_ASSERT_IMPLIES(a_ready_through, m_axis_tready, s_axis_tready, "input blocked while output ready")
  `MHC_ASSERT_IMPLIES(a_heading_range, m_axis_tvalid, m_axis_tdata[30:16] < 15'd23040, "heading out of one turn")
  `MHC_ASSERT_IMPLIES(a_empty_after_reset, $rose(rst_ni), !m_axis_tvalid, "result present after reset")

endmodule

// ----- tb/magnetometer_heading_cordic_test.sv -----
// Self-checking testbench of the magnetometer heading CORDIC: directed rows, then random samples.
module magnetometer_heading_cordic_test;
  import mhc_pkg::*;

  localparam int unsigned STAGES = 16;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  localparam longint HALF_TURN_Q16 = 205887;
  localparam longint DEG_SCALE = 938734;
  localparam longint FULL_TURN_DEG64 = 23040;
  localparam longint ANGLE_STEP [0:23] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [BEAR_W-1:0] bearing;
    logic [HEAD_W-1:0]        heading;
  } heading_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [15:0]      a;
    logic [15:0]      b;
    bit               typed;
    heading_t         res;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [IN_W-1:0] cfg_wdata_i = '0;

  // Local copy of the calibration registers.
  logic signed [15:0] hard_x = X_OFFSET_RST;
  logic signed [15:0] hard_y = Y_OFFSET_RST;
  logic [14:0] mount_rot = ROT_OFFSET_RST;

  heading_t pending_headings[$];
  int fail_count = 0;
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  int stall_left = 0;

  magnetometer_heading_cordic #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    // tdata: x_raw [15:0], y_raw [31:16]
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // tdata: bearing_rad [15:0], heading_deg [30:16], zero [31]
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Vectoring CORDIC; the angle comes back in radians * 65536.
  function automatic longint cordic_angle_q16(longint xs, longint ys);
    longint x, y, z, dx, dy;
    x = xs * 256;
    y = ys * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ANGLE_STEP[i];
      end else if (y < 0) begin
        x -= dx;
        y += dy;
        z -= ANGLE_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic heading_t compute_heading(logic [15:0] xr, logic [15:0] yr);
    logic signed [15:0] xc, yc;
    longint xl, yl, rot_l, z, b, h;
    heading_t r;
    xc = xr + hard_x;
    yc = yr + hard_y;
    xl = longint'(xc);
    yl = longint'(yc);
    rot_l = longint'(mount_rot);
    z = cordic_angle_q16(xl, yl);
    b = ((z + 8) >>> 4) - rot_l;
    // The heading is taken from the bearing before saturation.
    h = (b * DEG_SCALE + 524288) >>> 20;
    while (h < 0) h += FULL_TURN_DEG64;
    while (h >= FULL_TURN_DEG64) h -= FULL_TURN_DEG64;
    if (b > 32767) r.bearing = 16'sh7FFF;
    else if (b < -32768) r.bearing = 16'sh8000;
    else r.bearing = b[15:0];
    r.heading = h[14:0];
    return r;
  endfunction

  function automatic plan_row_t sample_row(logic [15:0] xr, logic [15:0] yr);
    plan_row_t r;
    r = '{ROW_SAMPLE, '0, xr, yr, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [15:0] xr, logic [15:0] yr,
                                          logic [15:0] bear, logic [14:0] head);
    plan_row_t r;
    r = '{ROW_SAMPLE, '0, xr, yr, 1'b1, heading_t'{bear, head}};
    return r;
  endfunction

  function automatic plan_row_t write_row(logic [IDX_W-1:0] idx, logic [15:0] data);
    plan_row_t r;
    r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
    return r;
  endfunction

  task automatic send_sample(input logic [15:0] xr, input logic [15:0] yr,
                             input bit typed, input heading_t typed_res);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yr, xr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_headings.push_back(typed ? typed_res : compute_heading(xr, yr));
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] data);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_headings.size() != 0);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_X_OFFSET:   hard_x = data;
      REG_Y_OFFSET:   hard_y = data;
      REG_ROT_OFFSET: mount_rot = data[14:0];
      default: ;
    endcase
  endtask

  // Receiver with random stall bursts.
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (sink_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
    m_axis_tready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    heading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_headings.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_headings.pop_front();
        if (m_axis_tdata[15:0] !== want.bearing) begin
          $display("%0t bearing mismatch: expected %0d, actual %0d", $time,
                   want.bearing, $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[30:16] !== want.heading) begin
          $display("%0t heading mismatch: expected %0d, actual %0d", $time,
                   want.heading, m_axis_tdata[30:16]);
          fail_count++;
        end
        if (m_axis_tdata[31] !== 1'b0) begin
          $display("%0t pad bit mismatch: expected 0, actual %b", $time, m_axis_tdata[31]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    logic [15:0] xr, yr, val, sx, sy, mag;
    int unsigned kind, pick;
    plan = '{
      // Reset calibration: the zero vector and both X half-axes.
      known_row(16'd1711, -16'sd2895, -16'sd17157, 15'd7680),
      known_row(16'd1811, -16'sd2895, -16'sd17157, 15'd7680),
      known_row(16'd1611, -16'sd2895, -16'sd4289, 15'd19200),
      write_row(REG_X_OFFSET, 16'h0000),
      write_row(REG_Y_OFFSET, 16'h0000),
      write_row(REG_ROT_OFFSET, 16'h0000),
      known_row(16'h0000, 16'h0000, 16'sd0, 15'd0),
      known_row(16'h7FFF, 16'h0000, 16'sd0, 15'd0),
      known_row(16'h8000, 16'h0000, 16'sd12868, 15'd11520),
      sample_row(16'h0000, 16'h7FFF),
      sample_row(16'h0000, 16'h8000),
      sample_row(16'h8000, 16'h8000),
      sample_row(16'h7FFF, 16'h7FFF),
      sample_row(16'h8000, 16'hFFFF),
      sample_row(16'hFFFF, 16'h0001),
      // Bit 15 of the rotation write is dropped; the bearing saturates low.
      write_row(REG_ROT_OFFSET, 16'hFFFF),
      sample_row(16'h8000, 16'hFFFF),
      known_row(16'h0000, 16'h0000, -16'sd32767, 15'd16745),
      sample_row(16'h8000, 16'h0000),
      write_row(REG_ROT_OFFSET, 16'h0000),
      write_row(REG_SPARE, 16'hFFFF),
      known_row(16'h8000, 16'h0000, 16'sd12868, 15'd11520),
      // Offsets that make the corrected values wrap around.
      write_row(REG_X_OFFSET, 16'h7FFF),
      write_row(REG_Y_OFFSET, 16'h8000),
      sample_row(16'h7FFF, 16'h7FFF),
      known_row(16'h8000, 16'h8000, 16'sd12868, 15'd11520),
      known_row(16'h8001, 16'h8000, 16'sd0, 15'd0),
      sample_row(16'h0001, 16'h8000),
      sample_row(16'h7FFF, 16'h0000)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle = 1'b1;
    sink_idle = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].a);
      else send_sample(plan[i].a, plan[i].b, plan[i].typed, plan[i].res);
    end

    for (int p = 0; p < 12; p++) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
      for (int r = 0; r < 3; r++) begin
        pick = $urandom_range(0, 4);
        if (pick == 0) val = (r == 2) ? 16'd0 : 16'h8000;
        else if (pick == 1) val = (r == 2) ? 16'd25735 : 16'h7FFF;
        else if (pick == 2) val = (r == 2) ? 16'hFFFF : 16'h0000;
        else val = 16'($urandom);
        write_reg(r[IDX_W-1:0], val);
      end
      // The last phase runs with no idling on either side.
      src_idle = (p < 11) && ($urandom_range(0, 3) != 0);
      sink_idle = (p < 11) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 150; n++) begin
        kind = $urandom_range(0, 9);
        sx = 16'($urandom_range(0, 16)) - 16'd8;
        sy = 16'($urandom_range(0, 16)) - 16'd8;
        mag = 16'($urandom);
        case (kind)
          5: begin
            xr = -hard_x;
            yr = -hard_y;
          end
          6: begin
            xr = 16'($urandom);
            yr = -hard_y;
          end
          7: begin
            xr = -hard_x;
            yr = 16'($urandom);
          end
          8: begin
            xr = sx - hard_x;
            yr = sy - hard_y;
          end
          9: begin
            xr = mag - hard_x;
            yr = ($urandom_range(0, 1) ? mag : -mag) - hard_y;
          end
          default: begin
            xr = 16'($urandom);
            yr = 16'($urandom);
          end
        endcase
        send_sample(xr, yr, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk_i);
    repeat (STAGES + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
